// ----- hdl/vghd_pkg.sv -----
// Shared types and constants for the voxel geodesic hop distance engine.
`default_nettype none
package vghd_pkg;

    // Volume extents are powers of two; coordinates are bit fields of the index.
    localparam int X_BITS  = 5;
    localparam int Y_BITS  = 5;
    localparam int Z_BITS  = 5;
    localparam int X_SIZE  = 1 << X_BITS;
    localparam int Y_SIZE  = 1 << Y_BITS;
    localparam int Z_SIZE  = 1 << Z_BITS;
    localparam int IDX_W   = X_BITS + Y_BITS + Z_BITS;
    localparam int NVOX    = 1 << IDX_W;
    localparam int CNT_W   = IDX_W + 1;

    localparam int VOX_W   = 15;
    localparam int DIST_W  = 15;
    localparam int LABEL_W = 8;
    localparam int CFG_W   = 2;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [CFG_W-1:0] CFG_TARGET = 2'd0;
    localparam logic [CFG_W-1:0] CFG_SOURCE = 2'd1;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_WALK  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                command;
        logic [VOX_W-1:0]    voxel_index;
        logic [LABEL_W-1:0]  label_in;
    } t_in_word;

    typedef struct packed {
        logic [DIST_W-1:0]   distance;
        logic [LABEL_W-1:0]  label_out;
        logic                is_border;
        logic [DIST_W-1:0]   reached_count;
    } t_out_word;

endpackage
`default_nettype wire

// ----- hdl/voxel_geodesic_hop_distance.sv -----
// Top level: label/distance stores, breadth-first walk sequencer, result register.
// Load and read: read the voxel's label and distance, then, for a source-labeled
//   voxel, scan its neighbors for a target label to set the border flag.
// Walk: the seed check, then per reached voxel a dequeue and a visit of every
//   neighbor offset, then the mark sweep over the queue fill, then the read path.
// Clear-distances: zeroes one distance entry a cycle, then the read path.
// One word is in flight at a time; the serial neighbor loop sets the rate.
// Reset (sync, active low): a clearing pass zeroes labels, distances and seen
//   marks; no input word is taken until it ends.
`default_nettype none
module voxel_geodesic_hop_distance
    import vghd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire t_in_word            i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output t_out_word                o_out_word,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CFG_W-1:0]    i_cfg_index,
    input  wire logic [LABEL_W-1:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SEED, S_SEED_CHK, S_DEQ, S_DEQ_WAIT, S_NB_RD, S_NB_UPD,
        S_UNMARK, S_FIN_RD, S_FIN_CHK, S_BD_RD, S_BD_CHK, S_DONE
    } t_state;

    t_state r_state;

    logic [LABEL_W-1:0] r_target, r_source;
    logic [IDX_W-1:0]   r_v, r_center;
    logic               r_clr_all;
    logic [CNT_W-1:0]   r_ptr, r_head, r_tail, r_level_end;
    logic               r_um_valid;
    logic [DIST_W-1:0]  r_level, r_reached;
    logic [1:0]         r_ox, r_oy, r_oz;
    logic [DIST_W-1:0]  r_res_dist;
    logic [LABEL_W-1:0] r_res_lab;
    logic               r_border;
    logic               r_out_valid;
    t_out_word          r_out_word;

    // Memories: label, distance, seen mark, BFS queue (filled linearly from 0).
    logic [LABEL_W-1:0] mem_lab  [NVOX];
    logic [DIST_W-1:0]  mem_dist [NVOX];
    logic               mem_seen [NVOX];
    logic [IDX_W-1:0]   mem_q    [NVOX];

    logic [LABEL_W-1:0] lab_rd, lab_wdata;
    logic [DIST_W-1:0]  dist_rd, dist_wdata;
    logic               seen_rd, seen_wdata;
    logic [IDX_W-1:0]   q_rd, q_wdata;
    logic [IDX_W-1:0]   lab_raddr, lab_waddr, dist_waddr, seen_waddr, q_raddr, q_waddr;
    logic               lab_we, dist_we, seen_we, q_we;

    // Neighbor generation around r_center
    logic [X_BITS:0]    ex;
    logic [Y_BITS:0]    ey;
    logic [Z_BITS:0]    ez;
    logic               nb_ok, nb_last;
    logic [IDX_W-1:0]   nb_idx;
    logic               tgt_hit, upd_hit;
    logic               in_acc, in_range;

    assign ex = {1'b0, r_center[X_BITS-1:0]} + (X_BITS+1)'(r_ox);
    assign ey = {1'b0, r_center[X_BITS +: Y_BITS]} + (Y_BITS+1)'(r_oy);
    assign ez = {1'b0, r_center[X_BITS+Y_BITS +: Z_BITS]} + (Z_BITS+1)'(r_oz);

    always_comb begin
        logic [X_BITS:0] nx;
        logic [Y_BITS:0] ny;
        logic [Z_BITS:0] nz;
        nx = ex - 1'b1;
        ny = ey - 1'b1;
        nz = ez - 1'b1;
        nb_ok = (ex != '0) && (ex <= (X_BITS+1)'(X_SIZE))
             && (ey != '0) && (ey <= (Y_BITS+1)'(Y_SIZE))
             && (ez != '0) && (ez <= (Z_BITS+1)'(Z_SIZE))
             && !(r_ox == 2'd1 && r_oy == 2'd1 && r_oz == 2'd1);
        nb_idx = {nz[Z_BITS-1:0], ny[Y_BITS-1:0], nx[X_BITS-1:0]};
    end

    assign nb_last = (r_ox == 2'd2) && (r_oy == 2'd2) && (r_oz == 2'd2);
    assign tgt_hit = (lab_rd != '0) && (lab_rd == r_target);
    assign upd_hit = tgt_hit && !seen_rd;

    assign in_acc   = i_in_valid && o_in_ready;
    assign in_range = ({1'b0, i_in_word.voxel_index} < (VOX_W+1)'(NVOX));

    // Memory port control
    always_comb begin
        lab_raddr  = (r_state == S_NB_RD || r_state == S_BD_RD) ? nb_idx : r_v;
        q_raddr    = (r_state == S_UNMARK) ? r_ptr[IDX_W-1:0] : r_head[IDX_W-1:0];

        lab_we     = 1'b0;
        lab_waddr  = r_ptr[IDX_W-1:0];
        lab_wdata  = '0;
        if (r_state == S_CLR && r_clr_all) begin
            lab_we = 1'b1;
        end else if (in_acc && in_range && i_in_word.command == CMD_LOAD) begin
            lab_we    = 1'b1;
            lab_waddr = i_in_word.voxel_index[IDX_W-1:0];
            lab_wdata = i_in_word.label_in;
        end

        dist_we    = 1'b0;
        dist_waddr = r_ptr[IDX_W-1:0];
        dist_wdata = '0;
        if (r_state == S_CLR) begin
            dist_we = 1'b1;
        end else if (r_state == S_NB_UPD && upd_hit &&
                     (dist_rd == '0 || r_level < dist_rd)) begin
            dist_we    = 1'b1;
            dist_waddr = nb_idx;
            dist_wdata = r_level;
        end

        seen_we    = 1'b0;
        seen_waddr = r_ptr[IDX_W-1:0];
        seen_wdata = 1'b0;
        case (r_state)
            S_CLR:      seen_we = r_clr_all;
            S_SEED_CHK: begin
                seen_we    = (lab_rd != '0);
                seen_waddr = r_v;
                seen_wdata = 1'b1;
            end
            S_NB_UPD:   begin
                seen_we    = upd_hit;
                seen_waddr = nb_idx;
                seen_wdata = 1'b1;
            end
            S_UNMARK:   begin
                seen_we    = r_um_valid;
                seen_waddr = q_rd;
            end
            default:    seen_we = 1'b0;
        endcase

        q_we    = 1'b0;
        q_waddr = r_tail[IDX_W-1:0];
        q_wdata = nb_idx;
        if (r_state == S_SEED_CHK) begin
            q_we    = (lab_rd != '0);
            q_waddr = '0;
            q_wdata = r_v;
        end else if (r_state == S_NB_UPD) begin
            q_we = upd_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lab_we) begin
            mem_lab[lab_waddr] <= lab_wdata;
        end
        lab_rd <= mem_lab[lab_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            mem_dist[dist_waddr] <= dist_wdata;
        end
        dist_rd <= mem_dist[lab_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (seen_we) begin
            mem_seen[seen_waddr] <= seen_wdata;
        end
        seen_rd <= mem_seen[nb_idx];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            mem_q[q_waddr] <= q_wdata;
        end
        q_rd <= mem_q[q_raddr];
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_all   <= 1'b1;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
            r_target    <= LABEL_W'(1);
            r_source    <= LABEL_W'(2);
            r_um_valid  <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_level_end <= '0;
            r_level     <= '0;
            r_reached   <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TARGET: r_target <= i_cfg_data;
                    CFG_SOURCE: r_source <= i_cfg_data;
                    default:    ;
                endcase
            end
            // S_DONE handles its own output slot
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == CNT_W'(NVOX - 1)) begin
                        r_state <= r_clr_all ? S_IDLE : S_FIN_RD;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_v       <= i_in_word.voxel_index[IDX_W-1:0];
                        r_reached <= '0;
                        r_ptr     <= '0;
                        r_clr_all <= 1'b0;
                        if (!in_range) begin
                            r_res_dist <= '0;
                            r_res_lab  <= '0;
                            r_border   <= 1'b0;
                            r_state    <= S_DONE;
                        end else begin
                            unique case (i_in_word.command)
                                CMD_WALK:  r_state <= S_SEED;
                                CMD_CLEAR: r_state <= S_CLR;
                                default:   r_state <= S_FIN_RD;
                            endcase
                        end
                    end
                end
                S_SEED: r_state <= S_SEED_CHK;
                S_SEED_CHK: begin
                    // empty seed reaches nothing
                    if (lab_rd != '0) begin
                        r_head      <= '0;
                        r_tail      <= CNT_W'(1);
                        r_level     <= DIST_W'(1);
                        r_level_end <= CNT_W'(1);
                        r_state     <= S_DEQ;
                    end else begin
                        r_state <= S_FIN_RD;
                    end
                end
                S_DEQ: begin
                    if (r_head == r_tail) begin
                        r_ptr      <= '0;
                        r_um_valid <= 1'b0;
                        r_state    <= S_UNMARK;
                    end else begin
                        // crossing into the next BFS level
                        if (r_head == r_level_end) begin
                            r_level_end <= r_tail;
                            if (r_level != DIST_MAX) begin
                                r_level <= r_level + 1'b1;
                            end
                        end
                        r_state <= S_DEQ_WAIT;
                    end
                end
                S_DEQ_WAIT: begin
                    r_center <= q_rd;
                    r_head   <= r_head + 1'b1;
                    r_ox     <= '0;
                    r_oy     <= '0;
                    r_oz     <= '0;
                    r_state  <= S_NB_RD;
                end
                S_NB_RD, S_BD_RD: begin
                    if (nb_ok) begin
                        r_state <= (r_state == S_NB_RD) ? S_NB_UPD : S_BD_CHK;
                    end else if (nb_last) begin
                        r_state <= (r_state == S_NB_RD) ? S_DEQ : S_DONE;
                    end else begin
                        if (r_ox != 2'd2) begin
                            r_ox <= r_ox + 1'b1;
                        end else begin
                            r_ox <= '0;
                            if (r_oy != 2'd2) begin
                                r_oy <= r_oy + 1'b1;
                            end else begin
                                r_oy <= '0;
                                r_oz <= r_oz + 1'b1;
                            end
                        end
                    end
                end
                S_NB_UPD, S_BD_CHK: begin
                    if (r_state == S_NB_UPD && upd_hit) begin
                        r_tail <= r_tail + 1'b1;
                        if (dist_rd == '0 && r_reached != DIST_MAX) begin
                            r_reached <= r_reached + 1'b1;
                        end
                    end
                    if (r_state == S_BD_CHK && tgt_hit) begin
                        r_border <= 1'b1;
                        r_state  <= S_DONE;
                    end else if (nb_last) begin
                        r_state <= (r_state == S_NB_UPD) ? S_DEQ : S_DONE;
                    end else begin
                        r_state <= (r_state == S_NB_UPD) ? S_NB_RD : S_BD_RD;
                        if (r_ox != 2'd2) begin
                            r_ox <= r_ox + 1'b1;
                        end else begin
                            r_ox <= '0;
                            if (r_oy != 2'd2) begin
                                r_oy <= r_oy + 1'b1;
                            end else begin
                                r_oy <= '0;
                                r_oz <= r_oz + 1'b1;
                            end
                        end
                    end
                end
                S_UNMARK: begin
                    // sweep queue entries, dropping seen marks one a cycle
                    if (r_ptr != r_tail) begin
                        r_ptr      <= r_ptr + 1'b1;
                        r_um_valid <= 1'b1;
                    end else begin
                        r_um_valid <= 1'b0;
                        if (!r_um_valid) begin
                            r_state <= S_FIN_RD;
                        end
                    end
                end
                S_FIN_RD: r_state <= S_FIN_CHK;
                S_FIN_CHK: begin
                    r_res_dist <= dist_rd;
                    r_res_lab  <= lab_rd;
                    r_border   <= 1'b0;
                    if (lab_rd != '0 && lab_rd == r_source) begin
                        r_center <= r_v;
                        r_ox     <= '0;
                        r_oy     <= '0;
                        r_oz     <= '0;
                        r_state  <= S_BD_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid                <= 1'b1;
                        r_out_word.distance        <= r_res_dist;
                        r_out_word.label_out       <= r_res_lab;
                        r_out_word.is_border       <= r_border;
                        r_out_word.reached_count   <= r_reached;
                        r_state                    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks
    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEQ || r_state == S_DEQ_WAIT) |-> r_head <= r_tail)
        else $error("queue head passed tail");

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_NB_UPD |-> r_tail <= CNT_W'(NVOX))
        else $error("queue overflow");

    a_level_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dist_we && r_state == S_NB_UPD |-> dist_wdata != '0)
        else $error("walk wrote zero distance");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("second word taken while busy");

    a_unmark_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UNMARK |-> r_ptr <= r_tail)
        else $error("mark sweep ran past queue fill");

endmodule
`default_nettype wire
